// ----- hw/rtl/multichannel_sliding_median_macros.svh -----
// ----------------------------------------------------------------------------
// multichannel_sliding_median assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SLIDING_MEDIAN_MACROS_SVH
`define MULTICHANNEL_SLIDING_MEDIAN_MACROS_SVH

// rule must hold in the same cycle as cond
`define MSM_ASSERT_NOW(lbl, cond, rule, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (rule)) \
		else $error(msg);

// rule must hold in the cycle after cond
`define MSM_ASSERT_NEXT(lbl, cond, rule, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (rule)) \
		else $error(msg);

`endif

// ----- hw/rtl/msm_pkg.sv -----
// ----------------------------------------------------------------------------
// msm_pkg
// Shared sizes, types and controller states of the sliding median filter.
// ----------------------------------------------------------------------------
package msm_pkg;

	localparam int CHANNELS = 6;
	localparam int WINDOW   = 5;
	localparam int CHAN_W   = 3;
	localparam int DATA_W   = 8;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int ADDR_W   = CH_W + POS_W;
	localparam int MEM_D    = 1 << ADDR_W;
	localparam int MED_RANK = (WINDOW - 1) / 2;
	localparam int TREE_N   = 1 << CH_W;

	typedef logic [DATA_W-1:0] sample_t;
	typedef logic [WINDOW-1:0][DATA_W-1:0] win_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_RANK,
		ST_UPD,
		ST_EMIT
	} msm_state_t;

endpackage

// ----- hw/rtl/msm_rank_sel.sv -----
// ----------------------------------------------------------------------------
// msm_rank_sel
// Picks the lower median of one window by ranking every entry in parallel.
// ----------------------------------------------------------------------------
module msm_rank_sel import msm_pkg::*; (
	input  logic    clk,
	input  win_t    win,
	output sample_t median
);

	logic [CNT_W-1:0] lt_c [WINDOW];
	logic [CNT_W-1:0] le_c [WINDOW];
	logic [WINDOW-1:0] hit_c;
	sample_t med_c;
	sample_t median_s1;

	// entry i is the median when fewer than rank+1 entries lie below it
	// and more than rank lie at or below it; duplicates all carry the same value
	always_comb begin
		med_c = '0;
		for (int i = 0; i < WINDOW; i++) begin
			lt_c[i] = '0;
			le_c[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				lt_c[i] = lt_c[i] + CNT_W'(win[j] < win[i]);
				le_c[i] = le_c[i] + CNT_W'(win[j] <= win[i]);
			end
			hit_c[i] = (lt_c[i] <= CNT_W'(MED_RANK)) && (CNT_W'(MED_RANK) < le_c[i]);
			med_c = med_c | ({DATA_W{hit_c[i]}} & win[i]);
		end
	end

	always_ff @(posedge clk) begin
		median_s1 <= med_c;
	end

	assign median = median_s1;

endmodule

// ----- hw/rtl/multichannel_sliding_median.sv -----
// ----------------------------------------------------------------------------
// multichannel_sliding_median
// Per-channel sliding window median with running max and min over channels.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake          payload
// in       sink       in_valid/in_stall  channel, sample
// out      source     out_valid/out_stall median_value, out_channel,
//                                        max_distance, min_distance
//
// after its beat is taken, a result goes through the states in order: ST_READ reads the
// window memory once per entry plus once more for read latency, ST_RANK ranks, ST_UPD
// updates the stored median and ST_EMIT loads it with the max/min tree; the next beat is
// taken only back in ST_IDLE. a beat on a channel beyond the last one skips to ST_EMIT.
// reset clears write pointers and stored medians; window entries not yet
// written since reset read as zero through the per-channel fill state.
// a stalled result waits in the output register while the next beat runs.
//
`include "multichannel_sliding_median_macros.svh"

module multichannel_sliding_median import msm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAN_W-1:0] channel,
	input  logic [DATA_W-1:0] sample,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] median_value,
	output logic [CHAN_W-1:0] out_channel,
	output logic [DATA_W-1:0] max_distance,
	output logic [DATA_W-1:0] min_distance
);

	msm_state_t state_q, state_d;

	logic [CHAN_W-1:0] ch_q;
	sample_t           smp_q;
	logic              rng_q;
	logic [CNT_W-1:0]  cnt_q;

	sample_t           mem [MEM_D];
	sample_t           rdata_q;
	win_t              win_q;
	sample_t           med;

	logic [POS_W-1:0]  wp_q   [CHANNELS];
	logic [CHANNELS-1:0] full_q;
	sample_t           chm_q  [CHANNELS];

	logic              out_valid_q;
	sample_t           med_o_q;
	logic [CHAN_W-1:0] ch_o_q;
	sample_t           hi_o_q;
	sample_t           lo_o_q;

	logic              in_acc;
	logic              in_rng;
	logic              mem_we;
	logic              cap_en;
	logic              upd_en;
	logic              out_load;
	logic              last_rd;
	logic [CH_W-1:0]   ch_idx;
	logic [POS_W-1:0]  wp_cur;
	logic              full_cur;
	logic [CNT_W-1:0]  cnt_m1;
	logic [POS_W-1:0]  cap_pos;
	sample_t           cap_val;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	sample_t           hi_n [2*TREE_N];
	sample_t           lo_n [2*TREE_N];

	assign in_acc  = in_valid && !in_stall;
	assign in_rng  = 32'(channel) < CHANNELS;
	assign last_rd = cnt_q == CNT_W'(WINDOW);
	assign ch_idx  = ch_q[CH_W-1:0];
	assign wp_cur  = wp_q[ch_idx];
	assign full_cur = full_q[ch_idx];
	assign cnt_m1  = cnt_q - CNT_W'(1);
	assign cap_pos = cnt_m1[POS_W-1:0];
	assign waddr   = {ch_idx, wp_cur};
	assign raddr   = {ch_idx, cnt_q[POS_W-1:0]};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = in_rng ? ST_READ : ST_EMIT;
				end
			end
			ST_READ: begin
				if (last_rd) begin
					state_d = ST_RANK;
				end
			end
			ST_RANK: state_d = ST_UPD;
			ST_UPD:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		in_stall = 1'b1;
		mem_we   = 1'b0;
		cap_en   = 1'b0;
		upd_en   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_READ: begin
				mem_we = cnt_q == '0;
				cap_en = cnt_q != '0;
			end
			ST_RANK: ;
			ST_UPD:  upd_en = 1'b1;
			ST_EMIT: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_q  <= channel;
			smp_q <= sample;
			rng_q <= in_rng;
		end
	end

	// window memory: new sample goes in at the write pointer on the first read cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= smp_q;
		end
		rdata_q <= mem[raddr];
	end

	// the slot under the write pointer holds the new sample, never-written slots are zero
	always_comb begin
		if (cap_pos == wp_cur) begin
			cap_val = smp_q;
		end else if (full_cur || (cap_pos < wp_cur)) begin
			cap_val = rdata_q;
		end else begin
			cap_val = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cap_en) begin
			win_q[cap_pos] <= cap_val;
		end
	end

	msm_rank_sel u_rank (
		.clk    (clk),
		.win    (win_q),
		.median (med)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c]  <= '0;
				chm_q[c] <= '0;
			end
		end else if (upd_en) begin
			chm_q[ch_idx] <= med;
			if (wp_cur == POS_W'(WINDOW - 1)) begin
				wp_q[ch_idx]   <= '0;
				full_q[ch_idx] <= 1'b1;
			end else begin
				wp_q[ch_idx] <= wp_cur + POS_W'(1);
			end
		end
	end

	// max/min tree over the stored medians, spare leaves copy channel zero
	always_comb begin
		for (int l = 0; l < TREE_N; l++) begin
			if (l < CHANNELS) begin
				hi_n[TREE_N + l] = chm_q[l];
				lo_n[TREE_N + l] = chm_q[l];
			end else begin
				hi_n[TREE_N + l] = chm_q[0];
				lo_n[TREE_N + l] = chm_q[0];
			end
		end
		hi_n[0] = '0;
		lo_n[0] = '0;
		for (int n = TREE_N - 1; n >= 1; n--) begin
			hi_n[n] = (hi_n[2*n] > hi_n[2*n+1]) ? hi_n[2*n] : hi_n[2*n+1];
			lo_n[n] = (lo_n[2*n] < lo_n[2*n+1]) ? lo_n[2*n] : lo_n[2*n+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			med_o_q <= rng_q ? med : '0;
			ch_o_q  <= ch_q;
			hi_o_q  <= hi_n[1];
			lo_o_q  <= lo_n[1];
		end
	end

	assign out_valid    = out_valid_q;
	assign median_value = med_o_q;
	assign out_channel  = ch_o_q;
	assign max_distance = hi_o_q;
	assign min_distance = lo_o_q;

	`MSM_ASSERT_NEXT(a_accept_busy, in_acc, in_stall,
		"input taken while a beat is in flight")
	`MSM_ASSERT_NOW(a_minmax_order, out_valid, max_distance >= min_distance,
		"max below min")
	`MSM_ASSERT_NOW(a_median_bounded, out_valid && (32'(out_channel) < CHANNELS),
		(median_value <= max_distance) && (median_value >= min_distance),
		"median outside max/min")
	`MSM_ASSERT_NOW(a_read_in_range, state_q == ST_READ, 32'(ch_q) < CHANNELS,
		"window read for a channel out of range")

endmodule
